// File: rtl/mph_pkg.sv
package mph_pkg;

  // Fixed-point layout of the smoothed average
  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 8;
  localparam int AVG_W       = SAMPLE_BITS + FRAC_BITS;

  // 9*avg + sample stays below 10 * 2^AVG_W, so four extra bits hold it
  localparam int SUM_W       = AVG_W + 4;

  // Divide by ten as a multiply by ceil(2^DIV_SHIFT / 10); exact for SUM_W-bit inputs
  localparam int                DIV_SHIFT = SUM_W + 4;
  localparam longint unsigned   DIV_MUL   = ((64'd1 << DIV_SHIFT) + 64'd9) / 64'd10;
  localparam int                MUL_W     = DIV_SHIFT - 3;
  localparam int                PROD_W    = SUM_W + MUL_W;

  // Field widths
  localparam int SAMPLE_W   = 12;
  localparam int TIME_W     = 32;
  localparam int TH_W       = 12;
  localparam int MS_W       = 16;
  localparam int LEVEL_W    = 12;
  localparam int EVENT_W    = 2;
  localparam int CMP_W      = (AVG_W > TH_W + FRAC_BITS) ? AVG_W : TH_W + FRAC_BITS;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int RES_W      = 1 + EVENT_W + LEVEL_W + 1 + 1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DRY_TH     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WET_TH     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DRY_SETTLE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WET_SETTLE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_OFF    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_ON     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ON     = 3'd6;

  // Register reset values
  localparam logic [TH_W-1:0] RST_DRY_TH     = 12'd400;
  localparam logic [TH_W-1:0] RST_WET_TH     = 12'd200;
  localparam logic [MS_W-1:0] RST_DRY_SETTLE = 16'd1000;
  localparam logic [MS_W-1:0] RST_WET_SETTLE = 16'd1000;
  localparam logic [MS_W-1:0] RST_MIN_OFF    = 16'd5000;
  localparam logic [MS_W-1:0] RST_MIN_ON     = 16'd3000;
  localparam logic [MS_W-1:0] RST_MAX_ON     = 16'd10000;

  // Pump event codes
  localparam logic [EVENT_W-1:0] EV_NONE       = 2'd0;
  localparam logic [EVENT_W-1:0] EV_ON         = 2'd1;
  localparam logic [EVENT_W-1:0] EV_OFF_WET    = 2'd2;
  localparam logic [EVENT_W-1:0] EV_OFF_SAFETY = 2'd3;

  typedef struct packed {
    logic [TH_W-1:0] dry_th;
    logic [TH_W-1:0] wet_th;
    logic [MS_W-1:0] dry_settle;
    logic [MS_W-1:0] wet_settle;
    logic [MS_W-1:0] min_off;
    logic [MS_W-1:0] min_on;
    logic [MS_W-1:0] max_on;
  } cfg_t;

  // Last member sits in the lowest bits
  typedef struct packed {
    logic               wet_settled;
    logic               dry_settled;
    logic [LEVEL_W-1:0] level_avg;
    logic [EVENT_W-1:0] pump_event;
    logic               pump_on;
  } res_t;

endpackage

// File: rtl/moisture_pump_hysteresis_controller.sv
// Path: an accepted word loads the average register and the time beside it; the result
// register takes the control decision from them and drives out_, held back while
// out_ stalls.
// Throughput: one word per cycle unless out_ stalls; the average and timer/pump loops
// each close through their own registers, so only back-pressure holds the input.
// Reset: synchronous, active low; clears the pipeline, the average-loaded flag, timers,
// pump state and loads every threshold and time register with its default.
module moisture_pump_hysteresis_controller
  import mph_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [11:0] moisture_sample, [43:12] now_ms, [47:44] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] pump_on, [2:1] pump_event, [14:3] level_avg, [15] dry_settled,
  // [16] wet_settled, [23:17] zero
  output logic [OUT_DATA_W-1:0] out_tdata,

  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t              cfg_r;
  logic              in_acc;
  logic              a_valid_r;
  logic [TIME_W-1:0] a_now_r;
  logic              b_adv;
  logic              step;
  logic [AVG_W-1:0]  avg;
  res_t              res;
  res_t              out_res_r;
  logic              out_valid_r;
  logic              dry_timing;
  logic              wet_timing;

  // Configuration registers: plain writes, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dry_th     <= RST_DRY_TH;
      cfg_r.wet_th     <= RST_WET_TH;
      cfg_r.dry_settle <= RST_DRY_SETTLE;
      cfg_r.wet_settle <= RST_WET_SETTLE;
      cfg_r.min_off    <= RST_MIN_OFF;
      cfg_r.min_on     <= RST_MIN_ON;
      cfg_r.max_on     <= RST_MAX_ON;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DRY_TH:     cfg_r.dry_th     <= cfg_wdata[TH_W-1:0];
        REG_WET_TH:     cfg_r.wet_th     <= cfg_wdata[TH_W-1:0];
        REG_DRY_SETTLE: cfg_r.dry_settle <= cfg_wdata[MS_W-1:0];
        REG_WET_SETTLE: cfg_r.wet_settle <= cfg_wdata[MS_W-1:0];
        REG_MIN_OFF:    cfg_r.min_off    <= cfg_wdata[MS_W-1:0];
        REG_MIN_ON:     cfg_r.min_on     <= cfg_wdata[MS_W-1:0];
        REG_MAX_ON:     cfg_r.max_on     <= cfg_wdata[MS_W-1:0];
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  // Result stage advances when the output register is empty or being taken;
  // the average stage takes a new word whenever it is empty or moving on.
  assign b_adv     = !out_valid_r || out_tready;
  assign in_tready = !a_valid_r || b_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign step      = a_valid_r && b_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_acc;
    end
  end

  // Hold the word's time next to the updated average
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_now_r <= in_tdata[SAMPLE_W +: TIME_W];
    end
  end

  // Smoothed average: updated at accept, registered for the control stage
  mph_ema u_ema (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_acc),
    .sample (in_tdata[SAMPLE_W-1:0]),
    .avg    (avg)
  );

  // Hysteresis timers and pump decision
  mph_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .avg        (avg),
    .now        (a_now_r),
    .cfg        (cfg_r),
    .res        (res),
    .dry_timing (dry_timing),
    .wet_timing (wet_timing)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - RES_W)'(0), out_res_r};

  // A dry and a wet timer never run together
  assert property (@(posedge clk) disable iff (!rst_n)
    !(dry_timing && wet_timing))
    else $error("dry and wet timers both running");

  // Input stalls only when the average stage is full behind a blocked output
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (a_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without back-pressure");

  // Event codes agree with the pump state reported beside them
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_res_r.pump_event != EV_ON) || out_res_r.pump_on) &&
                    ((out_res_r.pump_event == EV_NONE) ||
                     (out_res_r.pump_event == EV_ON) || !out_res_r.pump_on))
    else $error("pump event disagrees with pump state");

endmodule

// File: rtl/mph_ema.sv
module mph_ema
  import mph_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [AVG_W-1:0]    avg
);

  logic [AVG_W-1:0]  avg_r;
  logic [AVG_W-1:0]  avg_nxt;
  logic              loaded_r;
  logic [AVG_W-1:0]  sample_fix;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  assign sample_fix = {SAMPLE_BITS'(sample), {FRAC_BITS{1'b0}}};

  // 9*avg as shift and add, then divide by ten through the reciprocal
  assign sum  = (SUM_W'(avg_r) << 3) + SUM_W'(avg_r) + SUM_W'(sample_fix);
  assign prod = PROD_W'(sum) * PROD_W'(DIV_MUL);

  always_comb begin
    if (loaded_r) begin
      avg_nxt = AVG_W'(prod >> DIV_SHIFT);
    end else begin
      avg_nxt = sample_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
    end else if (load) begin
      loaded_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      avg_r <= avg_nxt;
    end
  end

  assign avg = avg_r;

endmodule

// File: rtl/mph_ctrl.sv
module mph_ctrl
  import mph_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [AVG_W-1:0]  avg,
  input  logic [TIME_W-1:0] now,
  input  cfg_t              cfg,
  output res_t              res,
  output logic              dry_timing,
  output logic              wet_timing
);

  logic [TIME_W-1:0]  dry_start_r, dry_start_nxt;
  logic [TIME_W-1:0]  wet_start_r, wet_start_nxt;
  logic               dry_timing_r, wet_timing_r;
  logic               pump_r, pump_nxt;
  logic [TIME_W-1:0]  toggle_r, toggle_nxt;
  logic [CMP_W-1:0]   avg_c, dry_c, wet_c;
  logic               dry_hit, wet_hit;
  logic               dry_ok, wet_ok;
  logic [TIME_W-1:0]  since_toggle;
  logic [EVENT_W-1:0] event_code;

  assign avg_c = CMP_W'(avg);
  assign dry_c = CMP_W'({cfg.dry_th, {FRAC_BITS{1'b0}}});
  assign wet_c = CMP_W'({cfg.wet_th, {FRAC_BITS{1'b0}}});

  // Dry test wins when thresholds cross
  assign dry_hit = avg_c > dry_c;
  assign wet_hit = !dry_hit && (avg_c < wet_c);

  assign dry_start_nxt = (dry_hit && !dry_timing_r) ? now : dry_start_r;
  assign wet_start_nxt = (wet_hit && !wet_timing_r) ? now : wet_start_r;

  assign dry_ok = dry_hit && ((now - dry_start_nxt) >= TIME_W'(cfg.dry_settle));
  assign wet_ok = wet_hit && ((now - wet_start_nxt) >= TIME_W'(cfg.wet_settle));
  assign since_toggle = now - toggle_r;

  always_comb begin
    pump_nxt   = pump_r;
    toggle_nxt = toggle_r;
    event_code = EV_NONE;
    priority if (!pump_r && dry_ok && since_toggle >= TIME_W'(cfg.min_off)) begin
      pump_nxt   = 1'b1;
      toggle_nxt = now;
      event_code = EV_ON;
    end else if (pump_r && wet_ok && since_toggle >= TIME_W'(cfg.min_on)) begin
      pump_nxt   = 1'b0;
      toggle_nxt = now;
      event_code = EV_OFF_WET;
    end else if (pump_r && since_toggle >= TIME_W'(cfg.max_on)) begin
      pump_nxt   = 1'b0;
      toggle_nxt = now;
      event_code = EV_OFF_SAFETY;
    end else begin
      // no event: hold pump state
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_timing_r <= 1'b0;
      wet_timing_r <= 1'b0;
      pump_r       <= 1'b0;
      toggle_r     <= '0;
      dry_start_r  <= '0;
      wet_start_r  <= '0;
    end else if (step) begin
      dry_timing_r <= dry_hit;
      wet_timing_r <= wet_hit;
      pump_r       <= pump_nxt;
      toggle_r     <= toggle_nxt;
      dry_start_r  <= dry_start_nxt;
      wet_start_r  <= wet_start_nxt;
    end
  end

  assign res.pump_on     = pump_nxt;
  assign res.pump_event  = event_code;
  assign res.level_avg   = LEVEL_W'(avg >> FRAC_BITS);
  assign res.dry_settled = dry_ok;
  assign res.wet_settled = wet_ok;

  assign dry_timing = dry_timing_r;
  assign wet_timing = wet_timing_r;

endmodule
